>>> rtl/stp_pkg.sv
`timescale 1ns / 1ps
// Package for the software timer pool: request and response structs, command and
// status codes, controller state type and size constants. No dependencies.
package stp_pkg;

   localparam int HANDLE_W       = 5;
   localparam int STAMP_W        = 16;
   localparam int KIND_W         = 3;
   localparam int STATUS_W       = 2;
   localparam int MAX_TIMERS     = 32;
   localparam int DEF_NUM_TIMERS = 32;
   localparam logic [STAMP_W-1:0] DEF_REBASE_LIMIT = 16'd30000;

   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
   } stp_req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]       given_handle;
      logic signed [STAMP_W-1:0] elapsed;
      logic [STATUS_W-1:0]       status;
   } stp_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_REBASE,
      ST_HOLD
   } stp_state_type;

endpackage

>>> rtl/stp_stamp_store.sv
`timescale 1ns / 1ps
// Start stamp store: one synchronous memory of stamps with a registered read port,
// plus per-entry written bits so that an entry never written reads as zero. Uses stp_pkg.
module stp_stamp_store #(
   parameter int NUM_TIMERS = stp_pkg::DEF_NUM_TIMERS,
   parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [stp_pkg::STAMP_W-1:0]  wr_data,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [stp_pkg::STAMP_W-1:0]  rd_data
);
   import stp_pkg::*;

   logic [STAMP_W-1:0]    mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] written_ff;
   logic [STAMP_W-1:0]    rd_data_ff;
   logic                  rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         rd_written_ff <= written_ff[rd_addr];
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

>>> rtl/soft_timer_pool.sv
`timescale 1ns / 1ps
// Software timer pool with a shared 16-bit tick counter. Top level; uses stp_pkg
// and the stamp store stp_stamp_store.
//
// Usage: each request on req_* carries one command (tick, allocate, free, restart,
// read elapsed) and yields exactly one response on rsp_*. The rebase limit is
// written through csr_valid/csr_data (csr_ready is always high) while no request
// is in flight. Tick below the limit, allocate, free, restart and a bad handle
// answer via the output register, waiting in the hold register if it is full.
// A read passes through ST_READ, as the stamp memory's read port is registered.
// A tick reaching the rebase limit walks the stamp memory, one timer per cycle,
// reading entry k while writing k-1 back; that walk sets the worst-case rate.
// The block takes one request at a time. A finished response waits in the output
// register while the next request is accepted; if the receiver stalls and that
// register is still full, the new result waits in a hold register and no further
// request is taken until it moves on. Reset clears the counter, frees all timers,
// zeroes all stamps (through written bits in the store) and sets the limit to
// 30000.
module soft_timer_pool #(
   parameter int NUM_TIMERS = stp_pkg::DEF_NUM_TIMERS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  stp_pkg::stp_req_type        req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output stp_pkg::stp_rsp_type        rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [stp_pkg::STAMP_W-1:0] csr_data
);
   import stp_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] WALK_END = CNT_W'(NUM_TIMERS);
   localparam logic [HANDLE_W:0] HANDLE_LIMIT = (HANDLE_W + 1)'(NUM_TIMERS);

   stp_state_type          state_ff, state_in;
   logic [STAMP_W-1:0]     tick_ff, tick_in;
   logic [STAMP_W-1:0]     limit_ff;
   logic [STAMP_W-1:0]     amt_ff, amt_in;
   logic [NUM_TIMERS-1:0]  busy_ff, busy_in;
   logic [CNT_W-1:0]       walk_ff, walk_in;
   stp_rsp_type            hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   stp_rsp_type            rsp_ff, rsp_in;

   // Stamp memory port signals.
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [STAMP_W-1:0]     wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [STAMP_W-1:0]     rd_data;

   logic                   req_fire;
   logic                   slot_free;
   logic                   in_range;
   logic [IDX_W-1:0]       h_idx;
   logic                   free_found;
   logic [IDX_W-1:0]       free_idx;
   logic [STAMP_W-1:0]     tick_next;
   logic [CNT_W-1:0]       walk_prev;
   stp_rsp_type            res;
   logic                   deliver;

   stp_stamp_store #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign in_range  = {1'b0, req_payload.handle} < HANDLE_LIMIT;
   assign h_idx     = req_payload.handle[IDX_W-1:0];
   assign tick_next = tick_ff + STAMP_W'(1);
   assign walk_prev = walk_ff - CNT_W'(1);

   // Lowest-numbered free timer; scanning downward lets the lowest one win.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      amt_in       = amt_ff;
      busy_in      = busy_ff;
      walk_in      = walk_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = h_idx;
      wr_data      = tick_ff;
      rd_addr      = h_idx;
      res          = '0;
      deliver      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               deliver = 1'b1;
               case (req_payload.kind)
                  KIND_TICK: begin
                     if (tick_next >= limit_ff) begin
                        // Rebase: stamps of busy timers move back by the count.
                        tick_in  = '0;
                        amt_in   = tick_next;
                        walk_in  = '0;
                        hold_in  = '0;
                        deliver  = 1'b0;
                        state_in = ST_REBASE;
                     end else begin
                        tick_in = tick_next;
                     end
                  end
                  KIND_ALLOC: begin
                     if (free_found) begin
                        busy_in[free_idx] = 1'b1;
                        res.given_handle  = HANDLE_W'(free_idx);
                     end else begin
                        res.status = STATUS_NONE_FREE;
                     end
                  end
                  KIND_FREE: begin
                     if (in_range) begin
                        busy_in[h_idx] = 1'b0;
                     end else begin
                        res.status = STATUS_BAD_HANDLE;
                     end
                  end
                  KIND_RESTART: begin
                     if (in_range) begin
                        wr_en = 1'b1;
                     end else begin
                        res.status = STATUS_BAD_HANDLE;
                     end
                  end
                  KIND_READ: begin
                     if (in_range) begin
                        deliver  = 1'b0;
                        state_in = ST_READ;
                     end else begin
                        res.status = STATUS_BAD_HANDLE;
                     end
                  end
                  default: begin
                     res = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            res.elapsed = $signed(tick_ff - rd_data);
            deliver     = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_REBASE: begin
            // Read entry walk while entry walk - 1 is written back.
            rd_addr = walk_ff[IDX_W-1:0];
            wr_addr = walk_prev[IDX_W-1:0];
            wr_data = rd_data - amt_ff;
            wr_en   = (walk_ff != '0) && busy_ff[walk_prev[IDX_W-1:0]];
            walk_in = walk_ff + CNT_W'(1);
            if (walk_ff == WALK_END) begin
               walk_in  = walk_ff;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished result goes to the output register if it is free, else it waits.
      if (deliver) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         limit_ff     <= DEF_REBASE_LIMIT;
         busy_ff      <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         busy_ff      <= busy_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      amt_ff  <= amt_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for soft_timer_pool: random and directed timer commands,
// with responses checked against a cycle-free shadow of the pool. Depends on stp_pkg.
module tb;
   import stp_pkg::*;

   localparam int NUM_TIMERS  = DEF_NUM_TIMERS;
   localparam int CYCLE_LIMIT = 800_000;
   localparam int LONG_STALL  = 400;

   // Command codes 5 to 7 carry no meaning; the pool must answer them with all zeros.
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid   = 1'b0;
   logic                req_ready;
   stp_req_type         req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   stp_rsp_type         rsp_payload;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [STAMP_W-1:0]  csr_data    = '0;

   soft_timer_pool #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Requests waiting to be offered, and responses the shadow pool has predicted.
   stp_req_type request_q[$];
   stp_rsp_type predicted_rsp[$];

   int n_queued      = 0;
   int n_req_taken   = 0;
   int n_csr_taken   = 0;
   int n_errors      = 0;
   int cycle_count   = 0;
   int send_gap      = 0;
   int rsp_wait      = 0;
   int stall_asked   = 0;
   int stall_granted = 0;
   logic req_taken   = 1'b0;
   logic idle_on     = 1'b1;

   // Shadow copy of the pool: shared counter, per-timer stamps and busy marks.
   logic [STAMP_W-1:0] rebase_limit = DEF_REBASE_LIMIT;
   logic [STAMP_W-1:0] tick_now     = '0;
   logic [STAMP_W-1:0] stamp_of [MAX_TIMERS];
   logic               busy_of  [MAX_TIMERS];

   initial begin
      forever #4 clock = ~clock;
   end

   // Applies one command to the shadow pool and returns the response it should give.
   function automatic stp_rsp_type timer_pool_outcome(input stp_req_type cmd);
      stp_rsp_type res;
      logic        found;
      int          t;
      res = '0;
      res.status = STATUS_OK;
      found = 1'b0;
      case (cmd.kind)
         KIND_TICK: begin
            // The counter wraps in 16 bits before it is compared with the limit.
            tick_now = tick_now + 16'd1;
            if (tick_now >= rebase_limit) begin
               // Rebase: only busy timers have their stamps shifted back.
               for (t = 0; t < NUM_TIMERS; t++) begin
                  if (busy_of[t]) stamp_of[t] = stamp_of[t] - tick_now;
               end
               tick_now = '0;
            end
         end
         KIND_ALLOC: begin
            res.status = STATUS_NONE_FREE;
            for (t = 0; t < NUM_TIMERS; t++) begin
               if (!found && !busy_of[t]) begin
                  found = 1'b1;
                  busy_of[t] = 1'b1;
                  res.given_handle = HANDLE_W'(t);
                  res.status = STATUS_OK;
               end
            end
         end
         KIND_FREE, KIND_RESTART, KIND_READ: begin
            if (int'(cmd.handle) >= NUM_TIMERS) begin
               res.status = STATUS_BAD_HANDLE;
            end else if (cmd.kind == KIND_FREE) begin
               busy_of[cmd.handle] = 1'b0;
            end else if (cmd.kind == KIND_RESTART) begin
               stamp_of[cmd.handle] = tick_now;
            end else begin
               // Free timers may be read too; they keep whatever stamp they had.
               res.elapsed = tick_now - stamp_of[cmd.handle];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Monitor: everything is sampled at the rising edge. Responses are checked before
   // the request accepted on the same edge is predicted, so a stray response can never
   // be matched against a request it could not belong to.
   always @(posedge clock) begin : monitor_proc
      int t;
      stp_rsp_type want;
      if (reset) begin
         rebase_limit = DEF_REBASE_LIMIT;
         tick_now = '0;
         for (t = 0; t < MAX_TIMERS; t++) begin
            stamp_of[t] = '0;
            busy_of[t] = 1'b0;
         end
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            rebase_limit = csr_data;
            n_csr_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response with no request outstanding: %p", rsp_payload);
               n_errors++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_payload.given_handle !== want.given_handle) begin
                  $error("given_handle: expected %0d, got %0d",
                         want.given_handle, rsp_payload.given_handle);
                  n_errors++;
               end
               if (rsp_payload.elapsed !== want.elapsed) begin
                  $error("elapsed: expected %0d, got %0d", want.elapsed, rsp_payload.elapsed);
                  n_errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  n_errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(timer_pool_outcome(req_payload));
            n_req_taken++;
         end
      end
   end

   // Driver: works on the falling edge. A request that has been offered is held until
   // the edge that takes it; after it, the sender may go quiet for a random burst.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_taken) begin
         // Still waiting for the pool to take the current request.
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (request_q.size() > 0) begin
         req_valid <= 1'b1;
         req_payload <= request_q.pop_front();
         send_gap <= (idle_on && $urandom_range(0, 99) < 10) ? $urandom_range(1, 15) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: short random stalls, plus a long hold-off on request from the main
   // sequence. During the long one the sender keeps offering, so the pool's output
   // and hold registers fill and it has to refuse further requests.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (stall_asked != stall_granted) begin
         stall_granted <= stall_asked;
         rsp_ready <= 1'b0;
         rsp_wait <= LONG_STALL;
      end else if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait <= rsp_wait - 1;
      end else if (idle_on && $urandom_range(0, 99) < 6) begin
         rsp_ready <= 1'b0;
         rsp_wait <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic queue_request(input logic [KIND_W-1:0] kind,
                                input logic [HANDLE_W-1:0] handle);
      stp_req_type r;
      r.kind = kind;
      r.handle = handle;
      request_q.push_back(r);
      n_queued++;
   endtask

   // Random command mix. Allocation and tick weights vary per phase so that some
   // phases fill the pool up to the point where allocation fails.
   task automatic queue_random(input int alloc_pct, input int tick_pct);
      int pick;
      logic [HANDLE_W-1:0] h;
      pick = $urandom_range(0, 99);
      h = HANDLE_W'($urandom_range(0, MAX_TIMERS - 1));
      if (pick < tick_pct) begin
         queue_request(KIND_TICK, h);
      end else if (pick < tick_pct + alloc_pct) begin
         queue_request(KIND_ALLOC, h);
      end else if (pick < tick_pct + alloc_pct + 10) begin
         queue_request(KIND_FREE, h);
      end else if (pick < 96) begin
         queue_request(($urandom_range(0, 2) == 0) ? KIND_RESTART : KIND_READ, h);
      end else begin
         queue_request(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), h);
      end
   endtask

   // Waits until every queued request has been taken and answered.
   task automatic drain();
      do @(negedge clock); while (n_req_taken != n_queued || predicted_rsp.size() != 0);
   endtask

   // One phase: with the pool idle, set a new rebase limit, then queue random commands.
   task automatic run_phase(input logic [STAMP_W-1:0] limit, input int count,
                            input int alloc_pct, input int tick_pct);
      int before_write;
      int k;
      drain();
      before_write = n_csr_taken;
      csr_data <= limit;
      csr_valid <= 1'b1;
      do @(negedge clock); while (n_csr_taken == before_write);
      csr_valid <= 1'b0;
      for (k = 0; k < count; k++) queue_random(alloc_pct, tick_pct);
   endtask

   initial begin
      int p;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening under the reset limit: grants from the bottom of the pool,
      // reads of a busy timer, of a free timer that was never stamped and of one that
      // was, double free, reuse of a freed handle, the spare command codes, and the
      // handle extremes.
      queue_request(KIND_ALLOC, 5'd0);
      queue_request(KIND_ALLOC, 5'd31);
      queue_request(KIND_RESTART, 5'd0);
      queue_request(KIND_TICK, 5'd0);
      queue_request(KIND_TICK, 5'd31);
      queue_request(KIND_READ, 5'd0);
      queue_request(KIND_READ, 5'd1);
      queue_request(KIND_RESTART, 5'd1);
      queue_request(KIND_READ, 5'd31);
      queue_request(KIND_RESTART, 5'd31);
      queue_request(KIND_READ, 5'd31);
      queue_request(KIND_FREE, 5'd1);
      queue_request(KIND_FREE, 5'd1);
      queue_request(KIND_ALLOC, 5'd10);
      queue_request(KIND_SPARE_LO, 5'd31);
      queue_request(KIND_SPARE_LO + 3'd1, 5'd0);
      queue_request(KIND_SPARE_HI, 5'd21);
      queue_request(KIND_TICK, 5'd10);
      queue_request(KIND_READ, 5'd0);
      queue_request(KIND_FREE, 5'd31);
      queue_request(KIND_READ, 5'd1);

      // A zero limit rebases on every tick, and a limit of one does the same work
      // through the ordinary compare.
      run_phase(16'd0, 60, 10, 40);
      run_phase(16'd1, 100, 10, 40);
      // Largest limit, with allocation weighted up so the pool runs out of timers.
      run_phase(16'hFFFF, 150, 30, 25);
      // Dropping the limit below the running count forces a rebase on the next tick.
      run_phase(16'd5, 200, 12, 40);
      @(posedge clock);
      stall_asked <= stall_asked + 1;
      for (p = 0; p < 4; p++) begin
         run_phase(STAMP_W'($urandom_range(2, 64)), 200, $urandom_range(5, 25), 40);
      end
      run_phase(STAMP_W'($urandom_range(1, 65535)), 100, 15, 35);
      @(posedge clock);
      stall_asked <= stall_asked + 1;
      run_phase(16'd17, 100, 15, 40);
      drain();
      // Final stretch at full rate on both sides.
      idle_on <= 1'b0;
      run_phase(16'd9, 250, 15, 40);

      drain();
      repeat (NUM_TIMERS + 8) @(negedge clock);
      if (n_errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
